[design/lmfs_pkg.sv]
// Shared types, codes and helpers of the LED matrix frame store mapper.
package lmfs_pkg;

    // Grid geometry (side length 2 to 8)
    localparam int GRID_DIM = 8;
    localparam int CELLS    = GRID_DIM * GRID_DIM;
    localparam int CW       = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
    localparam int AW       = $clog2(CELLS);
    localparam int IDX_W    = 6;
    localparam int CH_W     = 8;
    localparam int LVL_W    = 5;

    // Brightness scaling: divisor is DIV_BASE minus the stored level
    localparam logic [LVL_W-1:0] DIV_BASE  = 5'd21;
    localparam logic [7:0]       LEVEL_MIN = 8'd1;
    localparam logic [7:0]       LEVEL_MAX = 8'd20;

    // Command codes
    localparam logic [2:0] CMD_SET_PIXEL = 3'd0;
    localparam logic [2:0] CMD_FILL      = 3'd1;
    localparam logic [2:0] CMD_ON        = 3'd2;
    localparam logic [2:0] CMD_OFF       = 3'd3;
    localparam logic [2:0] CMD_CLEAR     = 3'd4;
    localparam logic [2:0] CMD_REFRESH   = 3'd5;
    localparam logic [2:0] CMD_SET_LEVEL = 3'd6;

    // Strip actions
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_BLANK = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OFF       = 2'd1;
    localparam logic [1:0] ST_BAD_LEVEL = 2'd2;

    // Divider operand source
    localparam logic SRC_COLOR = 1'b0;
    localparam logic SRC_STORE = 1'b1;

    typedef struct packed {
        logic [2:0] cmd;
        logic [2:0] col;
        logic [2:0] row;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] level;
    } t_in;

    typedef struct packed {
        logic [1:0]       action;
        logic [IDX_W-1:0] led_index;
        logic [7:0]       red_out;
        logic [7:0]       green_out;
        logic [7:0]       blue_out;
        logic             push_res;
        logic [1:0]       status;
        logic             last;
    } t_out;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    // Controller to datapath commands
    typedef struct packed {
        logic       cap;
        logic       load_level;
        logic       wr_pixel;
        logic       clear;
        logic       walk_rst;
        logic       walk_inc;
        logic       use_walk;
        logic       fill_wr;
        logic       rd;
        logic       div_start;
        logic       src;
        logic       emit;
        logic [1:0] action;
        logic       push;
        logic [1:0] status;
        logic       last;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
        logic walk_last;
        logic div_busy;
    } t_dp_stat;

    function automatic logic [AW-1:0] cell_addr(logic [CW-1:0] row, logic [CW-1:0] col);
        cell_addr = AW'(int'(row) * GRID_DIM + int'(col));
    endfunction

    // Serpentine strip position: odd rows run backwards
    function automatic logic [IDX_W-1:0] strip_pos(logic [CW-1:0] row, logic [CW-1:0] col);
        int c;
        c = row[0] ? (GRID_DIM - 1 - int'(col)) : int'(col);
        strip_pos = IDX_W'(int'(row) * GRID_DIM + c);
    endfunction

endpackage

[design/lmfs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module lmfs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/lmfs_div.sv]
// Three-lane restoring divider, one quotient bit per lane per cycle.
module lmfs_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lmfs_pkg::LVL_W-1:0]  i_divisor,
    input  lmfs_pkg::t_rgb              i_dividend,
    output logic                        o_busy,
    output lmfs_pkg::t_rgb              o_quot
);

    localparam int CNT_W = $clog2(lmfs_pkg::CH_W);

    logic [2:0][lmfs_pkg::CH_W-1:0]  w_dividend;
    logic [2:0][lmfs_pkg::CH_W-1:0]  r_quo;
    logic [2:0][lmfs_pkg::CH_W-1:0]  n_quo;
    logic [2:0][lmfs_pkg::LVL_W-1:0] r_rem;
    logic [2:0][lmfs_pkg::LVL_W-1:0] n_rem;
    logic [2:0][lmfs_pkg::LVL_W:0]   w_trial;
    logic [lmfs_pkg::LVL_W-1:0]      r_dvs;
    logic [CNT_W-1:0]                r_cnt;
    logic                            r_busy;

    assign w_dividend = i_dividend;

    // Shift in the next dividend bit, subtract where the divisor fits
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_trial[k] = {r_rem[k], r_quo[k][lmfs_pkg::CH_W-1]};
            if (w_trial[k] >= {1'b0, r_dvs}) begin
                n_rem[k] = lmfs_pkg::LVL_W'(w_trial[k] - {1'b0, r_dvs});
                n_quo[k] = {r_quo[k][lmfs_pkg::CH_W-2:0], 1'b1};
            end else begin
                n_rem[k] = w_trial[k][lmfs_pkg::LVL_W-1:0];
                n_quo[k] = {r_quo[k][lmfs_pkg::CH_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(lmfs_pkg::CH_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= w_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo;

endmodule

[design/lmfs_datapath.sv]
// Datapath: pixel store, walk counter, brightness divider and output register.
module lmfs_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lmfs_pkg::t_in      i_in,
    input  lmfs_pkg::t_dp_cmd  i_cmd,
    output lmfs_pkg::t_dp_stat o_stat,
    output logic               o_out_valid,
    output lmfs_pkg::t_out     o_out_data,
    input  logic               i_out_stall
);

    logic [lmfs_pkg::LVL_W-1:0] r_bright;
    lmfs_pkg::t_rgb             r_color;
    logic [lmfs_pkg::CW-1:0]    r_row;
    logic [lmfs_pkg::CW-1:0]    r_col;
    logic [lmfs_pkg::CW-1:0]    r_walk_row;
    logic [lmfs_pkg::CW-1:0]    r_walk_col;
    logic [lmfs_pkg::CELLS-1:0] r_valid;
    logic                       r_rd_valid;
    logic                       r_out_valid;
    lmfs_pkg::t_out             r_out;
    lmfs_pkg::t_out             n_out;

    lmfs_pkg::t_rgb             w_in_color;
    lmfs_pkg::t_rgb             w_ram_q;
    lmfs_pkg::t_rgb             w_store;
    lmfs_pkg::t_rgb             w_dividend;
    lmfs_pkg::t_rgb             w_quot;
    logic                       w_wr_en;
    logic [lmfs_pkg::AW-1:0]    w_wr_addr;
    lmfs_pkg::t_rgb             w_wr_data;
    logic [lmfs_pkg::AW-1:0]    w_walk_addr;
    logic [lmfs_pkg::CW-1:0]    w_row;
    logic [lmfs_pkg::CW-1:0]    w_col;
    logic                       w_walk_last;
    logic                       w_div_busy;
    logic [lmfs_pkg::LVL_W-1:0] w_divisor;

    assign w_in_color  = '{red: i_in.red_in, green: i_in.green_in, blue: i_in.blue_in};
    assign w_walk_addr = lmfs_pkg::cell_addr(r_walk_row, r_walk_col);
    assign w_walk_last = (r_walk_row == lmfs_pkg::CW'(lmfs_pkg::GRID_DIM - 1)) &&
                         (r_walk_col == lmfs_pkg::CW'(lmfs_pkg::GRID_DIM - 1));

    assign w_wr_en   = i_cmd.wr_pixel || i_cmd.fill_wr;
    assign w_wr_addr = i_cmd.wr_pixel
                     ? lmfs_pkg::cell_addr(i_in.row[lmfs_pkg::CW-1:0],
                                           i_in.col[lmfs_pkg::CW-1:0])
                     : w_walk_addr;
    assign w_wr_data = i_cmd.wr_pixel ? w_in_color : r_color;

    lmfs_ram #(
        .WIDTH ($bits(lmfs_pkg::t_rgb)),
        .DEPTH (lmfs_pkg::CELLS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (w_walk_addr),
        .o_rd_data (w_ram_q)
    );

    // Never-written cells read as black
    assign w_store    = r_rd_valid ? w_ram_q : '0;
    assign w_dividend = (i_cmd.src == lmfs_pkg::SRC_STORE) ? w_store : r_color;
    assign w_divisor  = lmfs_pkg::DIV_BASE - r_bright;

    lmfs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_divisor  (w_divisor),
        .i_dividend (w_dividend),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    assign w_row = i_cmd.use_walk ? r_walk_row : r_row;
    assign w_col = i_cmd.use_walk ? r_walk_col : r_col;

    always_comb begin
        n_out          = '0;
        n_out.action   = i_cmd.action;
        n_out.push_res = i_cmd.push;
        n_out.status   = i_cmd.status;
        n_out.last     = i_cmd.last;
        if (i_cmd.action == lmfs_pkg::ACT_WRITE) begin
            n_out.led_index = lmfs_pkg::strip_pos(w_row, w_col);
            n_out.red_out   = w_quot.red;
            n_out.green_out = w_quot.green;
            n_out.blue_out  = w_quot.blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright    <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_walk_row  <= '0;
            r_walk_col  <= '0;
        end else begin
            if (i_cmd.load_level) begin
                r_bright <= i_in.level[lmfs_pkg::LVL_W-1:0];
            end
            if (i_cmd.clear) begin
                r_valid <= '0;
            end else if (w_wr_en) begin
                r_valid[w_wr_addr] <= 1'b1;
            end
            if (i_cmd.walk_rst) begin
                r_walk_row <= '0;
                r_walk_col <= '0;
            end else if (i_cmd.walk_inc) begin
                if (r_walk_col == lmfs_pkg::CW'(lmfs_pkg::GRID_DIM - 1)) begin
                    r_walk_col <= '0;
                    r_walk_row <= r_walk_row + lmfs_pkg::CW'(1);
                end else begin
                    r_walk_col <= r_walk_col + lmfs_pkg::CW'(1);
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_color <= w_in_color;
            r_row   <= i_in.row[lmfs_pkg::CW-1:0];
            r_col   <= i_in.col[lmfs_pkg::CW-1:0];
        end
        if (i_cmd.rd) begin
            r_rd_valid <= r_valid[w_walk_addr];
        end
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_stat.out_free  = !r_out_valid || !i_out_stall;
    assign o_stat.walk_last = w_walk_last;
    assign o_stat.div_busy  = w_div_busy;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out;

    a_push_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.push_res && r_out.action == lmfs_pkg::ACT_WRITE)
        |-> r_out.last)
        else $error("refresh request on a pixel that does not end its command");

    a_non_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.action != lmfs_pkg::ACT_WRITE)
        |-> (r_out.led_index == '0 && r_out.red_out == '0 &&
             r_out.green_out == '0 && r_out.blue_out == '0))
        else $error("pixel fields set on a result that writes no pixel");

endmodule

[design/lmfs_ctrl.sv]
// Controller: command decode, grid on flag and per-pixel sequencing.
module lmfs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  lmfs_pkg::t_in      i_in,
    output lmfs_pkg::t_dp_cmd  o_cmd,
    input  lmfs_pkg::t_dp_stat i_stat
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_lights_on;
    logic       n_lights_on;
    logic       r_replay;
    logic       n_replay;
    logic       r_fill;
    logic       n_fill;
    logic       w_accept;
    logic       w_in_grid;
    logic       w_level_ok;

    assign o_in_stall = (r_state != S_IDLE) || !i_stat.out_free;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_in_grid  = (int'(i_in.col) < lmfs_pkg::GRID_DIM) &&
                        (int'(i_in.row) < lmfs_pkg::GRID_DIM);
    assign w_level_ok = (i_in.level >= lmfs_pkg::LEVEL_MIN) &&
                        (i_in.level <= lmfs_pkg::LEVEL_MAX);

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_lights_on = r_lights_on;
        n_replay    = r_replay;
        n_fill      = r_fill;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    // Single-result commands emit at once; multi-cycle ones clear emit
                    o_cmd.cap    = 1'b1;
                    o_cmd.emit   = 1'b1;
                    o_cmd.last   = 1'b1;
                    o_cmd.action = lmfs_pkg::ACT_NONE;
                    o_cmd.status = lmfs_pkg::ST_OK;
                    unique case (i_in.cmd)
                        lmfs_pkg::CMD_SET_PIXEL: begin
                            if (!r_lights_on) begin
                                o_cmd.status = lmfs_pkg::ST_OFF;
                            end else if (w_in_grid) begin
                                o_cmd.emit     = 1'b0;
                                o_cmd.last     = 1'b0;
                                o_cmd.wr_pixel = 1'b1;
                                n_replay       = 1'b0;
                                n_fill         = 1'b0;
                                n_state        = S_LOAD;
                            end
                        end
                        lmfs_pkg::CMD_FILL: begin
                            if (!r_lights_on) begin
                                o_cmd.status = lmfs_pkg::ST_OFF;
                            end else begin
                                o_cmd.emit     = 1'b0;
                                o_cmd.last     = 1'b0;
                                o_cmd.walk_rst = 1'b1;
                                n_replay       = 1'b1;
                                n_fill         = 1'b1;
                                n_state        = S_READ;
                            end
                        end
                        lmfs_pkg::CMD_ON: begin
                            o_cmd.emit     = 1'b0;
                            o_cmd.last     = 1'b0;
                            o_cmd.walk_rst = 1'b1;
                            n_lights_on    = 1'b1;
                            n_replay       = 1'b1;
                            n_fill         = 1'b0;
                            n_state        = S_READ;
                        end
                        lmfs_pkg::CMD_OFF: begin
                            n_lights_on  = 1'b0;
                            o_cmd.action = lmfs_pkg::ACT_BLANK;
                        end
                        lmfs_pkg::CMD_CLEAR: begin
                            o_cmd.clear  = 1'b1;
                            o_cmd.action = lmfs_pkg::ACT_BLANK;
                        end
                        lmfs_pkg::CMD_REFRESH: begin
                            o_cmd.push = 1'b1;
                        end
                        lmfs_pkg::CMD_SET_LEVEL: begin
                            if (!w_level_ok) begin
                                o_cmd.status = lmfs_pkg::ST_BAD_LEVEL;
                            end else begin
                                o_cmd.emit       = 1'b0;
                                o_cmd.last       = 1'b0;
                                o_cmd.load_level = 1'b1;
                                o_cmd.walk_rst   = 1'b1;
                                n_lights_on      = 1'b1;
                                n_replay         = 1'b1;
                                n_fill           = 1'b0;
                                n_state          = S_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                o_cmd.rd      = !r_fill;
                o_cmd.fill_wr = r_fill;
                n_state       = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.div_start = 1'b1;
                o_cmd.src       = (r_replay && !r_fill) ? lmfs_pkg::SRC_STORE
                                                        : lmfs_pkg::SRC_COLOR;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (!i_stat.div_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.use_walk = r_replay;
                o_cmd.action   = lmfs_pkg::ACT_WRITE;
                o_cmd.status   = lmfs_pkg::ST_OK;
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.push = r_replay && i_stat.walk_last;
                    o_cmd.last = !r_replay || i_stat.walk_last;
                    if (r_replay && !i_stat.walk_last) begin
                        o_cmd.walk_inc = 1'b1;
                        n_state        = S_READ;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lights_on <= 1'b0;
            r_replay    <= 1'b0;
            r_fill      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_lights_on <= n_lights_on;
            r_replay    <= n_replay;
            r_fill      <= n_fill;
        end
    end

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("result loaded while the output register is still held");

    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |=> i_stat.div_busy)
        else $error("divider not running after start");

    a_replay_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_replay && i_stat.walk_last && i_stat.out_free)
        |=> (r_state == S_IDLE))
        else $error("replay continued past the final cell");

endmodule

[design/led_matrix_frame_store_mapper.sv]
// Top level of the serpentine LED matrix frame store mapper.
//
// Drives a GRID_DIM x GRID_DIM serpentine LED strip from a frame store of
// 24-bit colors. Each input transaction carries one command; it produces one
// output transaction, or GRID_DIM*GRID_DIM transactions when the command
// replays the store (turn on, fill, accepted brightness set). Replayed pixels
// leave in row-major order, each tagged with its serpentine strip index (odd
// rows run backwards) and with every channel divided by 21 minus the
// brightness level; the final one carries push_res and last. Commands that
// give a single result (off, clear, refresh, rejected requests) are ready for
// the next transaction as soon as the output register frees. Each replayed
// pixel is read from the store (a fill writes its color there instead),
// loaded into the divider, run through the three-lane bit-serial divider (one
// quotient bit per cycle for the 8-bit channels) and loaded into the output
// register; a set pixel writes the store on acceptance and skips the read. The
// store comes out of reset black, and clear blackens it through per-cell valid
// flags, so there is no clearing pass. Input transactions are held off while a
// command is in flight or while a result waits downstream.
module led_matrix_frame_store_mapper (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  lmfs_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output lmfs_pkg::t_out o_out_data
);

    lmfs_pkg::t_dp_cmd  w_cmd;
    lmfs_pkg::t_dp_stat w_stat;

    // Sequence commands and hold the on flag
    lmfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in_data),
        .o_cmd      (w_cmd),
        .i_stat     (w_stat)
    );

    // Store, scale and present pixels
    lmfs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the LED matrix frame store mapper.
module tb_top;

    // The command field has one spare code; the block must answer it with a plain ok
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    localparam int RANDOM_ITEMS = 210;
    // Worst case: every command replays 64 pixels, every pixel
    // held by a receiver stall, every command behind a sender gap; then margin
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int DRAIN_CYCLES = 40;

    // Shadow of the frame store, power and brightness, plus the queue of strip
    // operations that the block still owes us, oldest first.
    class t_strip_op_scoreboard;
        logic [23:0]     frame_rgb [64];
        bit              grid_lit;
        logic [4:0]      bright;
        lmfs_pkg::t_out  owed_ops [$];
        int              mismatches;

        function void clear_state();
            foreach (frame_rgb[i]) frame_rgb[i] = '0;
            grid_lit   = 1'b0;
            bright     = '0;
            owed_ops.delete();
            mismatches = 0;
        endfunction

        function void owe_status(logic [1:0] action, logic push, logic [1:0] status);
            lmfs_pkg::t_out op;
            op          = '0;
            op.action   = action;
            op.push_res = push;
            op.status   = status;
            op.last     = 1'b1;
            owed_ops.push_back(op);
        endfunction

        // One strip write: serpentine position, every channel scaled down
        function void owe_pixel(int col, int row, logic [23:0] rgb, logic fin);
            lmfs_pkg::t_out op;
            int             divisor;
            int             pos;
            divisor      = int'(lmfs_pkg::DIV_BASE) - int'(bright);
            pos          = row * lmfs_pkg::GRID_DIM +
                           ((row % 2 == 1) ? (lmfs_pkg::GRID_DIM - 1 - col) : col);
            op           = '0;
            op.action    = lmfs_pkg::ACT_WRITE;
            op.led_index = lmfs_pkg::IDX_W'(pos);
            op.red_out   = 8'(int'(rgb[23:16]) / divisor);
            op.green_out = 8'(int'(rgb[15:8]) / divisor);
            op.blue_out  = 8'(int'(rgb[7:0]) / divisor);
            op.push_res  = fin;
            op.status    = lmfs_pkg::ST_OK;
            op.last      = fin;
            owed_ops.push_back(op);
        endfunction

        // Replay walks the store row-major and powers the grid up
        function void owe_replay();
            grid_lit = 1'b1;
            for (int row = 0; row < lmfs_pkg::GRID_DIM; row++)
                for (int col = 0; col < lmfs_pkg::GRID_DIM; col++)
                    owe_pixel(col, row, frame_rgb[(row * lmfs_pkg::GRID_DIM + col) % 64],
                              (row == lmfs_pkg::GRID_DIM - 1) &&
                              (col == lmfs_pkg::GRID_DIM - 1));
        endfunction

        function void note_command(lmfs_pkg::t_in c);
            logic [23:0] rgb;
            rgb = {c.red_in, c.green_in, c.blue_in};
            case (c.cmd)
                lmfs_pkg::CMD_SET_PIXEL: begin
                    if (!grid_lit) begin
                        owe_status(lmfs_pkg::ACT_NONE, 1'b0, lmfs_pkg::ST_OFF);
                    end else if (int'(c.col) >= lmfs_pkg::GRID_DIM ||
                                 int'(c.row) >= lmfs_pkg::GRID_DIM) begin
                        owe_status(lmfs_pkg::ACT_NONE, 1'b0, lmfs_pkg::ST_OK);
                    end else begin
                        frame_rgb[(int'(c.row) * lmfs_pkg::GRID_DIM + int'(c.col)) % 64] = rgb;
                        owe_pixel(int'(c.col), int'(c.row), rgb, 1'b0);
                        // a lone write closes its command but asks for no refresh
                        owed_ops[$].last = 1'b1;
                    end
                end
                lmfs_pkg::CMD_FILL: begin
                    if (!grid_lit) begin
                        owe_status(lmfs_pkg::ACT_NONE, 1'b0, lmfs_pkg::ST_OFF);
                    end else begin
                        for (int i = 0; i < lmfs_pkg::GRID_DIM * lmfs_pkg::GRID_DIM; i++)
                            frame_rgb[i % 64] = rgb;
                        owe_replay();
                    end
                end
                lmfs_pkg::CMD_ON: begin
                    owe_replay();
                end
                lmfs_pkg::CMD_OFF: begin
                    grid_lit = 1'b0;
                    owe_status(lmfs_pkg::ACT_BLANK, 1'b0, lmfs_pkg::ST_OK);
                end
                lmfs_pkg::CMD_CLEAR: begin
                    foreach (frame_rgb[i]) frame_rgb[i] = '0;
                    owe_status(lmfs_pkg::ACT_BLANK, 1'b0, lmfs_pkg::ST_OK);
                end
                lmfs_pkg::CMD_REFRESH: begin
                    owe_status(lmfs_pkg::ACT_NONE, 1'b1, lmfs_pkg::ST_OK);
                end
                lmfs_pkg::CMD_SET_LEVEL: begin
                    if (c.level < lmfs_pkg::LEVEL_MIN || c.level > lmfs_pkg::LEVEL_MAX) begin
                        owe_status(lmfs_pkg::ACT_NONE, 1'b0, lmfs_pkg::ST_BAD_LEVEL);
                    end else begin
                        bright = c.level[4:0];
                        owe_replay();
                    end
                end
                default: begin
                    owe_status(lmfs_pkg::ACT_NONE, 1'b0, lmfs_pkg::ST_OK);
                end
            endcase
        endfunction

        function void match_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, actual %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_strip_op(lmfs_pkg::t_out got);
            lmfs_pkg::t_out want;
            if (owed_ops.size() == 0) begin
                $error("unexpected strip operation: action %0d index %0d",
                       got.action, got.led_index);
                mismatches++;
                return;
            end
            want = owed_ops.pop_front();
            match_field("action",    8'(want.action),    8'(got.action));
            match_field("led_index", 8'(want.led_index), 8'(got.led_index));
            match_field("red_out",   want.red_out,       got.red_out);
            match_field("green_out", want.green_out,     got.green_out);
            match_field("blue_out",  want.blue_out,      got.blue_out);
            match_field("push_res",  8'(want.push_res),  8'(got.push_res));
            match_field("status",    8'(want.status),    8'(got.status));
            match_field("last",      8'(want.last),      8'(got.last));
        endfunction
    endclass

    // Every block input starts at a known value
    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           out_stall = 1'b0;
    lmfs_pkg::t_in  in_data   = '0;
    logic           in_stall;
    logic           out_valid;
    lmfs_pkg::t_out out_data;

    t_strip_op_scoreboard sb;
    int cycle_count = 0;
    int stall_phase_left = 0;
    int stall_mode = 0;

    always #1 clk = ~clk;

    led_matrix_frame_store_mapper u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    // Receiver: phases of random length that never stall, stall lightly or
    // stall heavily, so back-pressure lands on every step of a replay.
    always @(negedge clk) begin
        if (stall_phase_left == 0) begin
            stall_phase_left = $urandom_range(4, 60);
            stall_mode       = $urandom_range(0, 2);
        end
        stall_phase_left--;
        case (stall_mode)
            0:       out_stall = 1'b0;
            1:       out_stall = ($urandom_range(0, 3) == 0);
            default: out_stall = ($urandom_range(0, 3) != 0);
        endcase
    end

    // Check every output transaction at the edge that moves it
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_strip_op(out_data);
    end

    // Watchdog: a hung block or a missing result ends here
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("led_matrix_frame_store_mapper verification failed");
            $finish;
        end
    end

    function automatic lmfs_pkg::t_in make_cmd(logic [2:0] cmd, logic [2:0] col,
                                               logic [2:0] row, logic [7:0] r,
                                               logic [7:0] g, logic [7:0] b,
                                               logic [7:0] level);
        lmfs_pkg::t_in c;
        c.cmd      = cmd;
        c.col      = col;
        c.row      = row;
        c.red_in   = r;
        c.green_in = g;
        c.blue_in  = b;
        c.level    = level;
        return c;
    endfunction

    // Mostly pixel writes on a lit grid; when the grid is dark, usually bring it
    // back so that writes get past the power check. Unused fields stay random.
    function automatic lmfs_pkg::t_in random_command();
        lmfs_pkg::t_in c;
        logic [63:0]   raw;
        int            pick;
        raw  = {$urandom, $urandom};
        c    = raw[$bits(lmfs_pkg::t_in)-1:0];
        pick = $urandom_range(0, 99);
        if (!sb.grid_lit && pick < 60) begin
            c.cmd = (pick < 30) ? lmfs_pkg::CMD_ON : lmfs_pkg::CMD_SET_LEVEL;
            c.level = 8'($urandom_range(1, 20));
        end else if (pick < 55) begin
            c.cmd = lmfs_pkg::CMD_SET_PIXEL;
        end else if (pick < 61) begin
            c.cmd = lmfs_pkg::CMD_FILL;
        end else if (pick < 66) begin
            c.cmd = lmfs_pkg::CMD_ON;
        end else if (pick < 72) begin
            c.cmd = lmfs_pkg::CMD_OFF;
        end else if (pick < 76) begin
            c.cmd = lmfs_pkg::CMD_CLEAR;
        end else if (pick < 82) begin
            c.cmd = lmfs_pkg::CMD_REFRESH;
        end else if (pick < 94) begin
            c.cmd = lmfs_pkg::CMD_SET_LEVEL;
            if ($urandom_range(0, 2) != 0) c.level = 8'($urandom_range(1, 20));
        end else begin
            c.cmd = CMD_UNUSED;
        end
        return c;
    endfunction

    // Present one command at the falling edge and hold it until accepted.
    // Valid stays high on return so a burst continues without a bubble.
    task automatic send_command(input lmfs_pkg::t_in c);
        in_data  = c;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_command(c);
        @(negedge clk);
    endtask

    // Hold the sender off until the block has delivered everything it owes
    task automatic wait_for_drain();
        in_valid = 1'b0;
        while (sb.owed_ops.size() != 0) @(negedge clk);
    endtask

    initial begin
        int sent;
        int burst;
        int gap;
        sent = 0;
        sb   = new;
        sb.clear_state();

        // Hold reset, then release it at a falling edge
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed: power checks, rejected levels, spare code, corner pixels,
        // both brightness extremes, and turning on through a level set
        send_command(make_cmd(lmfs_pkg::CMD_SET_PIXEL, 3'd0, 3'd0, 8'hff, 8'hff, 8'hff, 8'd0));
        send_command(make_cmd(lmfs_pkg::CMD_FILL, 3'd7, 3'd7, 8'hff, 8'h00, 8'hff, 8'd5));
        send_command(make_cmd(lmfs_pkg::CMD_REFRESH, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'd0));
        send_command(make_cmd(CMD_UNUSED, 3'd7, 3'd7, 8'hff, 8'hff, 8'hff, 8'hff));
        send_command(make_cmd(lmfs_pkg::CMD_OFF, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'd0));
        send_command(make_cmd(lmfs_pkg::CMD_CLEAR, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'd0));
        send_command(make_cmd(lmfs_pkg::CMD_SET_LEVEL, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'd0));
        send_command(make_cmd(lmfs_pkg::CMD_SET_LEVEL, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'd21));
        send_command(make_cmd(lmfs_pkg::CMD_SET_LEVEL, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'd255));
        send_command(make_cmd(lmfs_pkg::CMD_ON, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'd0));
        send_command(make_cmd(lmfs_pkg::CMD_SET_PIXEL, 3'd0, 3'd0, 8'hff, 8'hff, 8'hff, 8'd0));
        send_command(make_cmd(lmfs_pkg::CMD_SET_PIXEL, 3'd7, 3'd0, 8'hff, 8'h00, 8'h80, 8'd0));
        send_command(make_cmd(lmfs_pkg::CMD_SET_PIXEL, 3'd0, 3'd1, 8'h15, 8'h2a, 8'hfe, 8'd0));
        send_command(make_cmd(lmfs_pkg::CMD_SET_PIXEL, 3'd7, 3'd7, 8'd20, 8'd21, 8'd42, 8'd0));
        send_command(make_cmd(lmfs_pkg::CMD_SET_PIXEL, 3'd3, 3'd4, 8'h00, 8'h00, 8'h00, 8'd0));
        send_command(make_cmd(lmfs_pkg::CMD_SET_LEVEL, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'd20));
        send_command(make_cmd(lmfs_pkg::CMD_SET_LEVEL, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'd1));
        send_command(make_cmd(lmfs_pkg::CMD_REFRESH, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'd0));
        send_command(make_cmd(lmfs_pkg::CMD_OFF, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'd0));
        send_command(make_cmd(lmfs_pkg::CMD_SET_PIXEL, 3'd2, 3'd2, 8'h11, 8'h22, 8'h33, 8'd0));
        send_command(make_cmd(lmfs_pkg::CMD_SET_LEVEL, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'd10));
        send_command(make_cmd(lmfs_pkg::CMD_FILL, 3'd0, 3'd0, 8'hff, 8'hff, 8'hff, 8'd0));
        send_command(make_cmd(lmfs_pkg::CMD_CLEAR, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'd0));
        send_command(make_cmd(lmfs_pkg::CMD_ON, 3'd0, 3'd0, 8'h00, 8'h00, 8'h00, 8'd0));
        wait_for_drain();

        // Random: bursts of back-to-back commands separated by random gaps,
        // some bursts with no gap at all, and an occasional full drain
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 8);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                send_command(random_command());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            if ($urandom_range(0, 29) == 0) wait_for_drain();
        end

        // Drain, then give the block time to show any stray transaction
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (sb.mismatches == 0 && sb.owed_ops.size() == 0) begin
            $display("led_matrix_frame_store_mapper verification clean");
        end else begin
            $display("led_matrix_frame_store_mapper verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
design/lmfs_pkg.sv
design/lmfs_ram.sv
design/lmfs_div.sv
design/lmfs_datapath.sv
design/lmfs_ctrl.sv
design/led_matrix_frame_store_mapper.sv
verif/tb_top.sv
